// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the scanner top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define LMPRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define LMPRS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/lmprs_pkg.sv -----
// Shared types and constants of the LED matrix row scanner.
package lmprs_pkg;

    // Default geometry
    localparam int HALF_ROWS_DEF = 16;
    localparam int COLUMNS_DEF   = 64;

    // Fixed field widths
    localparam int PIX_W   = 24;
    localparam int PHASE_W = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    // Item kinds
    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RED_OFF   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_OFF = 1'b1;

    // Controls for the column byte encoder
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               red_off;
        logic               green_off;
    } enc_ctrl_t;

endpackage

// ----- rtl/core/lmprs_ram.sv -----
// Generic simple dual-port RAM with registered read.
module lmprs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/lmprs_col_enc.sv -----
// Column byte encoder: PWM compare of one upper and one lower pixel.
module lmprs_col_enc
    import lmprs_pkg::*;
(
    input  logic [PIX_W-1:0] top_pix,
    input  logic [PIX_W-1:0] bot_pix,
    input  enc_ctrl_t        ctrl,
    output logic [7:0]       col_byte
);

    // value > phase*16+15 holds exactly when the high nibble exceeds phase
    function automatic logic lit(input logic [7:0] v, input logic [PHASE_W-1:0] ph);
        lit = (v[7:4] > ph);
    endfunction

    // Pack R1 G1 B1 R2 at bits 0..3, G2 B2 at bits 6..7
    always_comb
    begin
        col_byte    = 8'h00;
        col_byte[0] = !ctrl.red_off   && lit(top_pix[23:16], ctrl.phase);
        col_byte[1] = !ctrl.green_off && lit(top_pix[15:8], ctrl.phase);
        col_byte[2] = lit(top_pix[7:0], ctrl.phase);
        col_byte[3] = !ctrl.red_off   && lit(bot_pix[23:16], ctrl.phase);
        col_byte[6] = !ctrl.green_off && lit(bot_pix[15:8], ctrl.phase);
        col_byte[7] = lit(bot_pix[7:0], ctrl.phase);
    end

endmodule

// ----- rtl/core/led_matrix_pwm_row_scanner_unit.sv -----
// Top level of the LED matrix PWM row scanner.
//
// Input channel (in_valid / in_stall): mode 0 stores one RGB888 pixel at
// pixel_row / pixel_col, mode 1 advances the scan by one row. Output channel
// (out_valid / out_stall): an advance gives COLUMNS/4 words, each with the
// row lit now, the word index, four packed column bytes and last on the end.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 red_off,
// 1 green_off); write only while idle.
// A pixel write goes straight into the RAM of its half. An advance reads one
// upper and one lower pixel per cycle from two RAMs over their single read
// ports, pausing before the fourth column of a word while the output register
// holds an untaken word. No new item is taken during a scan: in_stall stays
// high until the last word has entered the output register.
// At reset a clearing pass zeroes the frame store, one entry of each half per
// cycle, over all HALF_ROWS * 2**ceil(log2(COLUMNS)) entries (1024 by
// default), with in_stall high; configuration writes are taken during it.
// A stall on the output holds the current word; the scan pauses before the
// fourth column read of the next word until the output register frees up.
// Items are handled one at a time, so store reads and writes never overlap.
module led_matrix_pwm_row_scanner_unit
    import lmprs_pkg::*;
#(
    parameter int HALF_ROWS = HALF_ROWS_DEF,
    parameter int COLUMNS   = COLUMNS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic [4:0]             pixel_row,
    input  logic [5:0]             pixel_col,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             row_address,
    output logic [3:0]             word_index,
    output logic [31:0]            pin_word,
    output logic                   last,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "assert_macros.svh"

    localparam int RW    = $clog2(HALF_ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = HALF_ROWS * (1 << CW);
    localparam int WORDS = COLUMNS / 4;
    localparam int WW    = $clog2(WORDS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    localparam logic [1:0] LANE_LAST = 2'd3;

    // Control registers
    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [RW-1:0]      scan_row_reg, scan_row_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [RW-1:0]      row_shown_reg, row_shown_next;
    logic [WW-1:0]      word_reg, word_next;
    logic [1:0]         lane_reg, lane_next;
    logic               issue_done_reg, issue_done_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               red_off_reg, green_off_reg;

    // Payload registers
    logic [1:0]         rd_lane_reg, rd_lane_next;
    logic [WW-1:0]      rd_word_reg, rd_word_next;
    logic [23:0]        acc_reg, acc_next;
    logic [3:0]         out_row_reg, out_row_next;
    logic [3:0]         out_index_reg, out_index_next;
    logic [31:0]        out_word_reg, out_word_next;
    logic               out_last_reg, out_last_next;

    // Datapath signals
    logic               in_accept, out_accept, out_free;
    logic               issue, last_issue, push, push_last, clearing;
    logic [6:0]         pr_ext, pr_local;
    logic [8:0]         pc_ext;
    logic               row_ok, col_ok, is_lower, wr_ok;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic               up_we, lo_we;
    logic [AW-1:0]      ram_waddr;
    logic [PIX_W-1:0]   ram_wdata;
    logic [PIX_W-1:0]   up_rdata, lo_rdata;
    logic [7:0]         col_byte;
    enc_ctrl_t          enc_ctrl;

    // Handshakes
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || out_accept;
    assign clearing   = (state_reg == ST_CLEAR);

    // Decode the pixel address of a write item
    assign pr_ext   = 7'(pixel_row);
    assign pc_ext   = 9'(pixel_col);
    assign row_ok   = pr_ext < 7'(2 * HALF_ROWS);
    assign col_ok   = pc_ext < 9'(COLUMNS);
    assign is_lower = pr_ext >= 7'(HALF_ROWS);
    assign pr_local = is_lower ? (pr_ext - 7'(HALF_ROWS)) : pr_ext;
    assign wr_addr  = {pr_local[RW-1:0], pc_ext[CW-1:0]};
    assign wr_ok    = in_accept && (mode == MODE_WRITE) && row_ok && col_ok;

    // Steer clearing pass or pixel write to the two halves
    assign up_we     = clearing || (wr_ok && !is_lower);
    assign lo_we     = clearing || (wr_ok && is_lower);
    assign ram_waddr = clearing ? clr_addr_reg : wr_addr;
    assign ram_wdata = clearing ? '0 : {red, green, blue};

    // Issue one column read per cycle; hold the fourth lane until output frees
    assign issue      = (state_reg == ST_SCAN) && !issue_done_reg &&
                        ((lane_reg != LANE_LAST) || out_free);
    assign last_issue = issue && (lane_reg == LANE_LAST) &&
                        (word_reg == WW'(WORDS - 1));
    assign rd_addr    = {scan_row_reg, CW'({word_reg, lane_reg})};
    assign push       = rd_valid_reg && (rd_lane_reg == LANE_LAST);
    assign push_last  = push && (rd_word_reg == WW'(WORDS - 1));

    lmprs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_upper_ram (
        .clk   (clk),
        .we    (up_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (up_rdata)
    );

    lmprs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_lower_ram (
        .clk   (clk),
        .we    (lo_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (lo_rdata)
    );

    assign enc_ctrl.phase     = phase_reg;
    assign enc_ctrl.red_off   = red_off_reg;
    assign enc_ctrl.green_off = green_off_reg;

    lmprs_col_enc u_col_enc (
        .top_pix  (up_rdata),
        .bot_pix  (lo_rdata),
        .ctrl     (enc_ctrl),
        .col_byte (col_byte)
    );

    // Sequencer: clear, accept items, walk the columns of a row pair
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        scan_row_next   = scan_row_reg;
        phase_next      = phase_reg;
        row_shown_next  = row_shown_reg;
        word_next       = word_reg;
        lane_next       = lane_reg;
        issue_done_next = issue_done_reg;
        rd_valid_next   = issue;
        rd_lane_next    = lane_reg;
        rd_word_next    = word_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && (mode == MODE_ADVANCE))
                begin
                    row_shown_next  = scan_row_reg;
                    word_next       = '0;
                    lane_next       = '0;
                    issue_done_next = 1'b0;
                    state_next      = ST_SCAN;
                    if (scan_row_reg == RW'(HALF_ROWS - 1))
                    begin
                        scan_row_next = '0;
                        phase_next    = phase_reg + 1'b1;
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    lane_next = lane_reg + 1'b1;
                    if (lane_reg == LANE_LAST)
                    begin
                        word_next = word_reg + 1'b1;
                    end
                end
                if (last_issue)
                begin
                    issue_done_next = 1'b1;
                end
                if (push_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Collect column bytes into a word, load the output register
    always_comb
    begin
        acc_next       = acc_reg;
        out_row_next   = out_row_reg;
        out_index_next = out_index_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_accept;

        if (rd_valid_reg)
        begin
            case (rd_lane_reg)
                2'd0:    acc_next[7:0]   = col_byte;
                2'd1:    acc_next[15:8]  = col_byte;
                2'd2:    acc_next[23:16] = col_byte;
                default: acc_next        = acc_reg;
            endcase
        end

        if (push)
        begin
            out_valid_next = 1'b1;
            out_row_next   = 4'(row_shown_reg);
            out_index_next = 4'(rd_word_reg);
            out_word_next  = {col_byte, acc_reg};
            out_last_next  = (rd_word_reg == WW'(WORDS - 1));
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            scan_row_reg   <= '0;
            phase_reg      <= '0;
            row_shown_reg  <= '0;
            word_reg       <= '0;
            lane_reg       <= '0;
            issue_done_reg <= 1'b1;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            scan_row_reg   <= scan_row_next;
            phase_reg      <= phase_next;
            row_shown_reg  <= row_shown_next;
            word_reg       <= word_next;
            lane_reg       <= lane_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_off_reg   <= 1'b0;
            green_off_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_OFF:   red_off_reg   <= cfg_data[0];
                REG_GREEN_OFF: green_off_reg <= cfg_data[0];
                default:       red_off_reg   <= red_off_reg;
            endcase
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        rd_lane_reg   <= rd_lane_next;
        rd_word_reg   <= rd_word_next;
        acc_reg       <= acc_next;
        out_row_reg   <= out_row_next;
        out_index_reg <= out_index_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign row_address = out_row_reg;
    assign word_index  = out_index_reg;
    assign pin_word    = out_word_reg;
    assign last        = out_last_reg;

    // A finished word never overwrites one that has not been taken
    `LMPRS_ASSERT(a_push_into_free, push |-> (!out_valid_reg || out_accept), "word overwritten")
    // The store is not written while a row pair is being read
    `LMPRS_ASSERT_NEVER(a_no_write_in_scan, (state_reg == ST_SCAN) && (up_we || lo_we), "write in scan")
    // The final word of a row ends the scan
    `LMPRS_ASSERT(a_last_ends_scan, push_last |=> (state_reg == ST_IDLE), "scan did not end")

endmodule
